// ===== rtl/tblca_pkg.sv =====
package tblca_pkg;

    // Field widths of the transaction payload
    localparam int LABEL_W  = 10;
    localparam int OPCODE_W = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_RESTART  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INORDER  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PREORDER = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd3;

    // Fixed-point shift of the reciprocal used for label reduction
    localparam int RECIP_SHIFT = 20;

endpackage

// ===== rtl/tblca_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module tblca_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tblca_lblred.sv =====
// Label reduction modulo MAX_NODES: reciprocal multiply, register,
// then back-multiply with a single compare-and-subtract correction.
// Output is valid in the cycle after the label settles.
module tblca_lblred #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                   clk,
    input  logic [tblca_pkg::LABEL_W-1:0]          label,
    output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] idx
);

    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW    = tblca_pkg::LABEL_W;
    localparam int RSH   = tblca_pkg::RECIP_SHIFT;
    localparam int RECIP = (1 << RSH) / MAX_NODES;
    localparam int RW    = RSH + 1;
    localparam int MW    = $clog2(MAX_NODES + 1);
    localparam int PW    = LW + RW;
    localparam int BW    = LW + MW;
    localparam int WW    = ((IW > LW) ? IW : LW) + 1;

    logic [PW-1:0] prod;
    logic [LW-1:0] q_reg;
    logic [BW-1:0] qm;
    logic [BW-1:0] rem;
    logic [WW-1:0] rem_ext;
    logic [WW-1:0] rem_fix;

    // Quotient estimate, low by at most one
    assign prod = PW'(label) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        q_reg <= prod[RSH +: LW];
    end

    // Remainder, below twice the modulus: one correction step
    assign qm      = BW'(q_reg) * BW'(MAX_NODES);
    assign rem     = BW'(label) - qm;
    assign rem_ext = WW'(rem[LW-1:0]);
    assign rem_fix = (rem_ext >= WW'(MAX_NODES)) ? (rem_ext - WW'(MAX_NODES)) : rem_ext;
    assign idx     = rem_fix[IW-1:0];

endmodule

// ===== rtl/tree_build_lca_engine_unit.sv =====
// Throughput: one transaction at a time; in_ready stays low until the item completes.
// Restart, inorder, root and dropped preorder: S_RED1, S_RED2. Other preorder adds S_P1,
// S_P2, an S_P3/S_P4 pair per stack entry read (each pop, plus the one that stops it),
// S_ATT0, S_ATT1. Query adds S_Q1, S_Q2/S_Q3 per lift of x, S_Q4/S_Q5/S_Q6 per lift of
// y, S_Q7/S_Q8/S_Q9 per climb step; S_Q7 waits for a free result register, then loads it.
// Reset: rst_n asynchronous, clears sequencer, stack and node counts, step count, current node, result valid.
module tree_build_lca_engine_unit #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tblca_pkg::OPCODE_W-1:0]      opcode,
    input  logic [tblca_pkg::LABEL_W-1:0]       label_a,
    input  logic [tblca_pkg::LABEL_W-1:0]       label_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tblca_pkg::LABEL_W-1:0]       ancestor
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LW = tblca_pkg::LABEL_W;
    localparam int WW = ((IW > LW) ? IW : LW) + 1;

    localparam logic [CW-1:0] MAXC = CW'(MAX_NODES);
    localparam logic [IW-1:0] DMAX = IW'(MAX_NODES - 1);

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RED1 = 5'd1;
    localparam logic [4:0] S_RED2 = 5'd2;
    localparam logic [4:0] S_P1   = 5'd3;
    localparam logic [4:0] S_P2   = 5'd4;
    localparam logic [4:0] S_P3   = 5'd5;
    localparam logic [4:0] S_P4   = 5'd6;
    localparam logic [4:0] S_ATT0 = 5'd7;
    localparam logic [4:0] S_ATT1 = 5'd8;
    localparam logic [4:0] S_Q1   = 5'd9;
    localparam logic [4:0] S_Q2   = 5'd10;
    localparam logic [4:0] S_Q3   = 5'd11;
    localparam logic [4:0] S_Q4   = 5'd12;
    localparam logic [4:0] S_Q5   = 5'd13;
    localparam logic [4:0] S_Q6   = 5'd14;
    localparam logic [4:0] S_Q7   = 5'd15;
    localparam logic [4:0] S_Q8   = 5'd16;
    localparam logic [4:0] S_Q9   = 5'd17;

    logic [4:0]                     state_reg, state_next;
    logic [tblca_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [LW-1:0]                  raw_a_reg, raw_a_next;
    logic [LW-1:0]                  raw_b_reg, raw_b_next;
    logic [IW-1:0]                  x_reg, x_next;
    logic [IW-1:0]                  y_reg, y_next;
    logic [IW-1:0]                  px_reg, px_next;
    logic [IW-1:0]                  top_reg, top_next;
    logic [IW-1:0]                  par_reg, par_next;
    logic [IW-1:0]                  dx_reg, dx_next;
    logic [IW-1:0]                  dy_reg, dy_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [CW-1:0]                  stk_cnt_reg, stk_cnt_next;
    logic [CW-1:0]                  in_cnt_reg, in_cnt_next;
    logic [CW-1:0]                  pre_cnt_reg, pre_cnt_next;
    logic [IW-1:0]                  cur_reg, cur_next;
    logic                           out_valid_reg, out_valid_next;
    logic [LW-1:0]                  ancestor_reg, ancestor_next;

    logic [IW-1:0] red_a, red_b;
    logic [CW-1:0] stk_m1, stk_m2;
    logic [WW-1:0] x_ext;

    // Table ports
    logic          pos_we, par_we, dep_we, stk_we;
    logic [IW-1:0] pos_waddr, par_waddr, dep_waddr, stk_waddr;
    logic [IW-1:0] pos_wdata, par_wdata, dep_wdata, stk_wdata;
    logic [IW-1:0] pos_raddr, par_raddr, dep_raddr, stk_raddr;
    logic [IW-1:0] pos_rdata, par_rdata, dep_rdata, stk_rdata;

    // Label reducers
    tblca_lblred #(.MAX_NODES(MAX_NODES)) u_red_a (
        .clk   (clk),
        .label (raw_a_reg),
        .idx   (red_a)
    );

    tblca_lblred #(.MAX_NODES(MAX_NODES)) u_red_b (
        .clk   (clk),
        .label (raw_b_reg),
        .idx   (red_b)
    );

    // Tables: inorder position, parent, depth, open-node stack
    tblca_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );

    tblca_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_par (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    tblca_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_dep (
        .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
        .raddr(dep_raddr), .rdata(dep_rdata)
    );

    tblca_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign stk_m1 = stk_cnt_reg - CW'(1);
    assign stk_m2 = stk_cnt_reg - CW'(2);
    assign x_ext  = WW'(x_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign ancestor  = ancestor_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        raw_a_next     = raw_a_reg;
        raw_b_next     = raw_b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        px_next        = px_reg;
        top_next       = top_reg;
        par_next       = par_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        n_next         = n_reg;
        stk_cnt_next   = stk_cnt_reg;
        in_cnt_next    = in_cnt_reg;
        pre_cnt_next   = pre_cnt_reg;
        cur_next       = cur_reg;
        ancestor_next  = ancestor_reg;
        out_valid_next = out_valid_reg && !out_ready;

        pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0; pos_raddr = '0;
        par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_raddr = '0;
        dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0; dep_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_a_next = label_a;
                    raw_b_next = label_b;
                    op_next    = opcode;
                    state_next = S_RED1;
                end
            end

            S_RED1:
            begin
                state_next = S_RED2;
            end

            // Labels reduced: dispatch on opcode
            S_RED2:
            begin
                x_next = red_a;
                y_next = red_b;
                case (op_reg)
                    tblca_pkg::OP_RESTART:
                    begin
                        stk_cnt_next = '0;
                        in_cnt_next  = '0;
                        pre_cnt_next = '0;
                        state_next   = S_IDLE;
                    end
                    tblca_pkg::OP_INORDER:
                    begin
                        if (in_cnt_reg < MAXC)
                        begin
                            pos_we      = 1'b1;
                            pos_waddr   = red_a;
                            pos_wdata   = in_cnt_reg[IW-1:0];
                            in_cnt_next = in_cnt_reg + CW'(1);
                        end
                        state_next = S_IDLE;
                    end
                    tblca_pkg::OP_PREORDER:
                    begin
                        if (pre_cnt_reg >= MAXC)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (pre_cnt_reg == '0)
                        begin
                            // root is its own parent at depth zero
                            par_we       = 1'b1;
                            par_waddr    = red_a;
                            par_wdata    = red_a;
                            dep_we       = 1'b1;
                            dep_waddr    = red_a;
                            dep_wdata    = '0;
                            cur_next     = red_a;
                            stk_cnt_next = '0;
                            pre_cnt_next = CW'(1);
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            pre_cnt_next = pre_cnt_reg + CW'(1);
                            pos_raddr    = red_a;
                            state_next   = S_P1;
                        end
                    end
                    default:
                    begin
                        dep_raddr  = red_b;
                        n_next     = '0;
                        state_next = S_Q1;
                    end
                endcase
            end

            S_P1:
            begin
                px_next    = pos_rdata;
                pos_raddr  = cur_reg;
                state_next = S_P2;
            end

            // Left child: push previous node; else walk the stack unless it is empty
            S_P2:
            begin
                par_next = cur_reg;
                if (px_reg < pos_rdata)
                begin
                    if (stk_cnt_reg < MAXC)
                    begin
                        stk_we       = 1'b1;
                        stk_waddr    = stk_cnt_reg[IW-1:0];
                        stk_wdata    = cur_reg;
                        stk_cnt_next = stk_cnt_reg + CW'(1);
                    end
                    state_next = S_ATT0;
                end
                else if (stk_cnt_reg == '0)
                begin
                    state_next = S_ATT0;
                end
                else
                begin
                    stk_raddr  = stk_m1[IW-1:0];
                    state_next = S_P3;
                end
            end

            S_P3:
            begin
                top_next   = stk_rdata;
                pos_raddr  = stk_rdata;
                state_next = S_P4;
            end

            // Pop while the open node lies left of the new node
            S_P4:
            begin
                if (pos_rdata < px_reg)
                begin
                    par_next     = top_reg;
                    stk_cnt_next = stk_m1;
                    if (stk_m1 != '0)
                    begin
                        stk_raddr  = stk_m2[IW-1:0];
                        state_next = S_P3;
                    end
                    else
                    begin
                        state_next = S_ATT0;
                    end
                end
                else
                begin
                    state_next = S_ATT0;
                end
            end

            S_ATT0:
            begin
                dep_raddr  = par_reg;
                state_next = S_ATT1;
            end

            // Record parent and saturated depth
            S_ATT1:
            begin
                par_we     = 1'b1;
                par_waddr  = x_reg;
                par_wdata  = par_reg;
                dep_we     = 1'b1;
                dep_waddr  = x_reg;
                dep_wdata  = (dep_rdata < DMAX) ? (dep_rdata + IW'(1)) : DMAX;
                cur_next   = x_reg;
                state_next = S_IDLE;
            end

            S_Q1:
            begin
                dy_next    = dep_rdata;
                dep_raddr  = x_reg;
                state_next = S_Q2;
            end

            // Lift x to the depth of y
            S_Q2:
            begin
                dx_next = dep_rdata;
                if ((n_reg < MAXC) && (dep_rdata > dy_reg))
                begin
                    par_raddr  = x_reg;
                    n_next     = n_reg + CW'(1);
                    state_next = S_Q3;
                end
                else
                begin
                    n_next     = '0;
                    state_next = S_Q4;
                end
            end

            S_Q3:
            begin
                x_next     = par_rdata;
                dep_raddr  = par_rdata;
                state_next = S_Q2;
            end

            // Lift y to the depth of x
            S_Q4:
            begin
                if ((n_reg < MAXC) && (dx_reg < dy_reg))
                begin
                    par_raddr  = y_reg;
                    n_next     = n_reg + CW'(1);
                    state_next = S_Q5;
                end
                else
                begin
                    n_next     = '0;
                    state_next = S_Q7;
                end
            end

            S_Q5:
            begin
                y_next     = par_rdata;
                dep_raddr  = par_rdata;
                state_next = S_Q6;
            end

            S_Q6:
            begin
                dy_next    = dep_rdata;
                state_next = S_Q4;
            end

            // Climb both until they meet, then hand off the result
            S_Q7:
            begin
                if ((n_reg < MAXC) && (x_reg != y_reg))
                begin
                    par_raddr  = x_reg;
                    n_next     = n_reg + CW'(1);
                    state_next = S_Q8;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ancestor_next  = x_ext[LW-1:0];
                    state_next     = S_IDLE;
                end
            end

            S_Q8:
            begin
                x_next     = par_rdata;
                par_raddr  = y_reg;
                state_next = S_Q9;
            end

            S_Q9:
            begin
                y_next     = par_rdata;
                state_next = S_Q7;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            stk_cnt_reg   <= '0;
            in_cnt_reg    <= '0;
            pre_cnt_reg   <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            stk_cnt_reg   <= stk_cnt_next;
            in_cnt_reg    <= in_cnt_next;
            pre_cnt_reg   <= pre_cnt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        raw_a_reg    <= raw_a_next;
        raw_b_reg    <= raw_b_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        px_reg       <= px_next;
        top_reg      <= top_next;
        par_reg      <= par_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        ancestor_reg <= ancestor_next;
    end

endmodule

// ===== rtl/tblca_chk.sv =====
// Port-level checks for the tree/LCA engine.
module tblca_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [tblca_pkg::OPCODE_W-1:0] opcode,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [tblca_pkg::LABEL_W-1:0]  ancestor
);

    logic [1:0] owed_reg, owed_next;
    logic       q_acc, o_acc;

    // Query results owed: one in the output register, one in flight
    assign q_acc = in_valid && in_ready && (opcode == tblca_pkg::OP_QUERY);
    assign o_acc = out_valid && out_ready;

    always_comb
    begin
        owed_next = owed_reg;
        if (q_acc && !o_acc)
        begin
            owed_next = owed_reg + 2'd1;
        end
        else if (!q_acc && o_acc)
        begin
            owed_next = owed_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= 2'd0;
        end
        else
        begin
            owed_reg <= owed_next;
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ancestor))
        else $error("result changed while stalled");

    // Every transaction keeps the engine busy for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // A result is shown only when a query is owed
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed_reg != 2'd0)
        else $error("result without query");

    // At most one result waits while another query is worked
    a_owed_max: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg != 2'd3)
        else $error("too many query results outstanding");

endmodule

bind tree_build_lca_engine_unit tblca_chk u_tblca_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ancestor  (ancestor)
);

// ===== sim/tb_tree_build_lca_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_tree_build_lca_engine_unit;

    localparam int LABEL_W  = tblca_pkg::LABEL_W;
    localparam int OPCODE_W = tblca_pkg::OPCODE_W;

    localparam int NODES     = 1024;
    localparam int CHAIN_LEN = 128;
    localparam logic [LABEL_W-1:0] DEPTH_CAP = LABEL_W'(NODES - 1);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode    = tblca_pkg::OP_RESTART;
    logic [LABEL_W-1:0]  label_a   = '0;
    logic [LABEL_W-1:0]  label_b   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [LABEL_W-1:0]  ancestor;

    // Idle rates in percent of cycles, per side
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int items_sent   = 0;
    int err_count    = 0;

    // Tree state as the block should hold it
    logic [LABEL_W-1:0] pos_tab [NODES];
    logic [LABEL_W-1:0] par_tab [NODES];
    logic [LABEL_W-1:0] dep_tab [NODES];
    logic [LABEL_W-1:0] stk_tab [NODES];
    int                 stk_cnt  = 0;
    int                 ino_cnt  = 0;
    int                 pre_cnt  = 0;
    logic [LABEL_W-1:0] cur_node = '0;

    // Which labels have defined table entries, for legal stimulus
    bit                 ino_known  [NODES];
    bit                 node_known [NODES];
    logic [LABEL_W-1:0] ino_labels [$];
    logic [LABEL_W-1:0] all_nodes  [$];
    logic [LABEL_W-1:0] tree_nodes [$];

    // Ancestors still owed by the block, oldest first
    logic [LABEL_W-1:0] lca_expect_q [$];

    tree_build_lca_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .label_a   (label_a),
        .label_b   (label_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ancestor  (ancestor)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Tree predictor
    // ---------------------------------------------------------------

    function automatic logic [LABEL_W-1:0] rand_label();
        return LABEL_W'($urandom_range(NODES - 1));
    endfunction

    function automatic logic [LABEL_W-1:0] chain_label();
        return LABEL_W'($urandom_range(CHAIN_LEN - 1));
    endfunction

    function automatic void place_node(input logic [LABEL_W-1:0] x);
        tree_nodes.push_back(x);
        if (!node_known[x])
        begin
            node_known[x] = 1'b1;
            all_nodes.push_back(x);
        end
    endfunction

    function automatic void link_child(input logic [LABEL_W-1:0] node,
                                       input logic [LABEL_W-1:0] parent);
        logic [LABEL_W-1:0] d;
        d = dep_tab[parent];
        par_tab[node] = parent;
        dep_tab[node] = (d < DEPTH_CAP) ? d + 1'b1 : DEPTH_CAP;
        cur_node = node;
    endfunction

    function automatic void grow_preorder(input logic [LABEL_W-1:0] x);
        logic [LABEL_W-1:0] prev;
        logic [LABEL_W-1:0] px;
        logic [LABEL_W-1:0] par;
        if (pre_cnt >= NODES)
            return;
        place_node(x);
        // first node after a restart becomes the root, its own parent
        if (pre_cnt == 0)
        begin
            par_tab[x] = x;
            dep_tab[x] = '0;
            cur_node   = x;
            stk_cnt    = 0;
            pre_cnt    = 1;
            return;
        end
        pre_cnt++;
        prev = cur_node;
        px   = pos_tab[x];
        if (px < pos_tab[prev])
        begin
            // left child: previous node stays open on the stack
            if (stk_cnt < NODES)
            begin
                stk_tab[stk_cnt] = prev;
                stk_cnt++;
            end
            link_child(x, prev);
        end
        else if (stk_cnt == 0 || pos_tab[stk_tab[stk_cnt - 1]] > px)
        begin
            link_child(x, prev);
        end
        else
        begin
            // right child of the last open node passed in inorder
            par = prev;
            while (stk_cnt > 0 && pos_tab[stk_tab[stk_cnt - 1]] < px)
            begin
                par = stk_tab[stk_cnt - 1];
                stk_cnt--;
            end
            link_child(x, par);
        end
    endfunction

    function automatic logic [LABEL_W-1:0] predict_lca(input logic [LABEL_W-1:0] x,
                                                       input logic [LABEL_W-1:0] y);
        int n;
        for (n = 0; n < NODES && dep_tab[x] > dep_tab[y]; n++)
            x = par_tab[x];
        for (n = 0; n < NODES && dep_tab[x] < dep_tab[y]; n++)
            y = par_tab[y];
        for (n = 0; n < NODES && x != y; n++)
        begin
            x = par_tab[x];
            y = par_tab[y];
        end
        return x;
    endfunction

    function automatic void apply_transaction(input logic [OPCODE_W-1:0] op,
                                              input logic [LABEL_W-1:0]  a,
                                              input logic [LABEL_W-1:0]  b);
        case (op)
            tblca_pkg::OP_RESTART:
            begin
                stk_cnt = 0;
                ino_cnt = 0;
                pre_cnt = 0;
                tree_nodes.delete();
            end
            tblca_pkg::OP_INORDER:
            begin
                if (ino_cnt < NODES)
                begin
                    pos_tab[a] = LABEL_W'(ino_cnt);
                    ino_cnt++;
                    if (!ino_known[a])
                    begin
                        ino_known[a] = 1'b1;
                        ino_labels.push_back(a);
                    end
                end
            end
            tblca_pkg::OP_PREORDER:
                grow_preorder(a);
            default:
                lca_expect_q.push_back(predict_lca(a, b));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driving and checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // One transaction: optional idle cycles, then hold valid until taken.
    // Entered and left at a falling edge.
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic [LABEL_W-1:0]  a,
                             input logic [LABEL_W-1:0]  b);
        int idle;
        idle = 0;
        while ($urandom_range(99) < snd_idle_pct)
            idle++;
        apply_transaction(op, a, b);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        label_a  <= a;
        label_b  <= b;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every owed ancestor is back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (lca_expect_q.size() != 0);
    endtask

    task automatic send_random_query();
        logic [LABEL_W-1:0] x;
        logic [LABEL_W-1:0] y;
        if (tree_nodes.size() > 0 && $urandom_range(99) < 85)
        begin
            x = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
            y = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
        end
        else
        begin
            // labels from older trees: stale chains, possibly no meeting point
            x = all_nodes[$urandom_range(all_nodes.size() - 1)];
            y = all_nodes[$urandom_range(all_nodes.size() - 1)];
        end
        send_item(tblca_pkg::OP_QUERY, x, y);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);

    // Compare each returned ancestor against the oldest owed one
    always @(posedge clk)
    begin : result_check
        logic [LABEL_W-1:0] want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (lca_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("ancestor %0d with no query pending", ancestor));
            end
            else
            begin
                want = lca_expect_q.pop_front();
                if (ancestor !== want)
                    report_mismatch($sformatf("ancestor got %0d want %0d", ancestor, want));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Five-node tree with pushes, pops, extreme and alternating labels
    task automatic test_basic_tree();
        send_item(tblca_pkg::OP_RESTART, 10'h3FF, 10'h3FF);
        send_item(tblca_pkg::OP_INORDER, 10'h155, 10'h000);
        send_item(tblca_pkg::OP_INORDER, 10'h000, 10'h3FF);
        send_item(tblca_pkg::OP_INORDER, 10'h3FF, 10'h2AA);
        send_item(tblca_pkg::OP_INORDER, 10'h200, 10'h155);
        send_item(tblca_pkg::OP_INORDER, 10'h2AA, 10'h000);
        send_item(tblca_pkg::OP_PREORDER, 10'h200, 10'h3FF);
        send_item(tblca_pkg::OP_PREORDER, 10'h000, 10'h000);
        send_item(tblca_pkg::OP_PREORDER, 10'h155, 10'h2AA);
        send_item(tblca_pkg::OP_PREORDER, 10'h3FF, 10'h155);
        send_item(tblca_pkg::OP_PREORDER, 10'h2AA, 10'h3FF);
        send_item(tblca_pkg::OP_QUERY, 10'h155, 10'h3FF);
        send_item(tblca_pkg::OP_QUERY, 10'h3FF, 10'h2AA);
        send_item(tblca_pkg::OP_QUERY, 10'h000, 10'h000);
        send_item(tblca_pkg::OP_QUERY, 10'h155, 10'h200);
        send_item(tblca_pkg::OP_QUERY, 10'h2AA, 10'h2AA);
    endtask

    // Root alone, with its inorder slot left over from the previous tree
    task automatic test_single_node();
        send_item(tblca_pkg::OP_RESTART, 10'h000, 10'h000);
        send_item(tblca_pkg::OP_PREORDER, 10'h155, 10'h155);
        send_item(tblca_pkg::OP_QUERY, 10'h155, 10'h155);
    endtask

    // Repeated preorder label: the right-branch search pops nothing, the
    // node hangs off the previous one and forms a loop. Querying that loop
    // against a root of an older tree runs the climbs to their step cap.
    task automatic test_equal_positions();
        send_item(tblca_pkg::OP_RESTART, 10'h2AA, 10'h155);
        send_item(tblca_pkg::OP_INORDER, 10'd5, 10'd0);
        send_item(tblca_pkg::OP_INORDER, 10'd9, 10'd0);
        send_item(tblca_pkg::OP_PREORDER, 10'd9, 10'd0);
        send_item(tblca_pkg::OP_PREORDER, 10'd5, 10'd0);
        send_item(tblca_pkg::OP_PREORDER, 10'd9, 10'd0);
        send_item(tblca_pkg::OP_QUERY, 10'd9, 10'd5);
        send_item(tblca_pkg::OP_QUERY, 10'd9, 10'h200);
    endtask

    // Long left chain: deep tree and tall stack, queried against itself
    // and against a label left over from the first tree
    task automatic test_deep_chain();
        int i;
        send_item(tblca_pkg::OP_RESTART, rand_label(), rand_label());
        for (i = 0; i < CHAIN_LEN; i++)
            send_item(tblca_pkg::OP_INORDER, i[LABEL_W-1:0], rand_label());
        for (i = CHAIN_LEN - 1; i >= 0; i--)
            send_item(tblca_pkg::OP_PREORDER, i[LABEL_W-1:0], rand_label());
        send_item(tblca_pkg::OP_QUERY, 10'd0, 10'h3FF);
        send_item(tblca_pkg::OP_QUERY, 10'h3FF, 10'd0);
        send_item(tblca_pkg::OP_QUERY, 10'd0, 10'd1);
        send_item(tblca_pkg::OP_QUERY, 10'd63, 10'd64);
        repeat (3) send_item(tblca_pkg::OP_QUERY, chain_label(), chain_label());
    endtask

    // Well-formed tree: distinct labels, random inorder, random shape
    task automatic run_tree_episode();
        int n;
        int shape;
        int i;
        int lo;
        int hi;
        int r;
        int lo_stk [$];
        int hi_stk [$];
        logic [LABEL_W-1:0] labels [$];
        logic [LABEL_W-1:0] lbl;
        bit taken [NODES];
        n = ($urandom_range(99) < 15) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        shape = $urandom_range(5);
        for (i = 0; i < NODES; i++)
            taken[i] = 1'b0;
        while (labels.size() < n)
        begin
            lbl = rand_label();
            if (!taken[lbl])
            begin
                taken[lbl] = 1'b1;
                labels.push_back(lbl);
            end
        end
        send_item(tblca_pkg::OP_RESTART, rand_label(), rand_label());
        for (i = 0; i < n; i++)
            send_item(tblca_pkg::OP_INORDER, labels[i], rand_label());
        // preorder walk over inorder index ranges, left subtree first
        lo_stk.push_back(0);
        hi_stk.push_back(n - 1);
        while (lo_stk.size() > 0)
        begin
            lo = lo_stk.pop_back();
            hi = hi_stk.pop_back();
            if (lo <= hi)
            begin
                case (shape)
                    0:       r = lo;
                    1:       r = hi;
                    default: r = $urandom_range(hi, lo);
                endcase
                send_item(tblca_pkg::OP_PREORDER, labels[r], rand_label());
                lo_stk.push_back(r + 1);
                hi_stk.push_back(hi);
                lo_stk.push_back(lo);
                hi_stk.push_back(r - 1);
            end
        end
        repeat ($urandom_range(6, 1)) send_random_query();
    endtask

    // Malformed sequences: duplicate inorder labels, preorder orders that
    // fit no tree, trees grown without a restart, stale-label queries
    task automatic run_broken_episode();
        int kind;
        int m;
        int i;
        logic [LABEL_W-1:0] fresh [$];
        logic [LABEL_W-1:0] lbl;
        kind = $urandom_range(3);
        case (kind)
            0:
            begin
                send_item(tblca_pkg::OP_RESTART, rand_label(), rand_label());
                m = $urandom_range(10, 1);
                for (i = 0; i < m; i++)
                begin
                    if (fresh.size() > 0 && $urandom_range(99) < 30)
                        lbl = fresh[$urandom_range(fresh.size() - 1)];
                    else
                        lbl = rand_label();
                    fresh.push_back(lbl);
                    send_item(tblca_pkg::OP_INORDER, lbl, rand_label());
                end
                repeat ($urandom_range(m + 2, 1))
                begin
                    if ($urandom_range(99) < 75)
                        lbl = fresh[$urandom_range(fresh.size() - 1)];
                    else
                        lbl = ino_labels[$urandom_range(ino_labels.size() - 1)];
                    send_item(tblca_pkg::OP_PREORDER, lbl, rand_label());
                end
            end
            1:
            begin
                repeat ($urandom_range(4, 1))
                    send_item(tblca_pkg::OP_PREORDER,
                              ino_labels[$urandom_range(ino_labels.size() - 1)],
                              rand_label());
            end
            2:
            begin
                // queries only
            end
            default:
            begin
                m = $urandom_range(4, 1);
                for (i = 0; i < m; i++)
                begin
                    lbl = rand_label();
                    fresh.push_back(lbl);
                    send_item(tblca_pkg::OP_INORDER, lbl, rand_label());
                end
                repeat ($urandom_range(4, 1))
                begin
                    lbl = fresh[$urandom_range(fresh.size() - 1)];
                    // inorder past the node limit was dropped
                    if (!ino_known[lbl])
                        lbl = ino_labels[$urandom_range(ino_labels.size() - 1)];
                    send_item(tblca_pkg::OP_PREORDER, lbl, rand_label());
                end
            end
        endcase
        repeat ($urandom_range(5, 1)) send_random_query();
    endtask

    // Mostly well-formed trees, the rest noise; every episode ends on a query
    task automatic test_random_trees(input int count);
        int stop_at;
        stop_at = items_sent + count;
        wait_results_drained();
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 78)
                run_tree_episode();
            else
                run_broken_episode();
            if ($urandom_range(99) < 10)
                wait_results_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin : main_seq
        int guard;
        snd_idle_pct = 34;
        rcv_idle_pct = 62;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basic_tree();
        test_single_node();
        test_equal_positions();
        test_random_trees(140);

        snd_idle_pct = 62;
        rcv_idle_pct = 34;
        test_deep_chain();
        test_random_trees(135);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_trees(135);

        // drain, then let the last transaction settle
        in_valid <= 1'b0;
        guard = 0;
        while (lca_expect_q.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        if (lca_expect_q.size() != 0)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            repeat (50) @(negedge clk);
            if (err_count == 0 && lca_expect_q.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Watchdog
    initial
    begin
        #(200_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
